// ----- rtl/esc_pkg.sv -----
// esc_pkg: shared types, character codes and entity tables for the HTML escaper.
// No dependencies; imported by every module of the escaper.
`timescale 1ns / 1ps

package esc_pkg;

    localparam int ESC_QUEUE_DEPTH = 4;
    localparam int IDX_W           = 3;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_QUOT = 8'h22;
    localparam logic [7:0] CHAR_AMP  = 8'h26;
    localparam logic [7:0] CHAR_APOS = 8'h27;
    localparam logic [7:0] CHAR_LT   = 8'h3C;
    localparam logic [7:0] CHAR_GT   = 8'h3E;

    typedef enum logic [2:0] {
        KIND_PASS,
        KIND_AMP,
        KIND_LT,
        KIND_GT,
        KIND_QUOT,
        KIND_APOS,
        KIND_BRK
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
    } desc_t;

    function automatic logic [IDX_W-1:0] kind_len(input kind_t kind);
        logic [IDX_W-1:0] len;
        case (kind)
            KIND_PASS: len = IDX_W'(1);
            KIND_AMP:  len = IDX_W'(5);
            KIND_LT:   len = IDX_W'(4);
            KIND_GT:   len = IDX_W'(4);
            KIND_QUOT: len = IDX_W'(6);
            KIND_APOS: len = IDX_W'(5);
            KIND_BRK:  len = IDX_W'(5);
            default:   len = IDX_W'(1);
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kind_byte(input kind_t kind, input logic [IDX_W-1:0] idx,
                                             input logic [7:0] ch);
        logic [7:0] b;
        b = CHAR_AMP;
        case (kind)
            KIND_PASS: b = ch;
            KIND_AMP:
            begin
                case (idx)
                    3'd0:    b = "&";
                    3'd1:    b = "a";
                    3'd2:    b = "m";
                    3'd3:    b = "p";
                    default: b = ";";
                endcase
            end
            KIND_LT:
            begin
                case (idx)
                    3'd0:    b = "&";
                    3'd1:    b = "l";
                    3'd2:    b = "t";
                    default: b = ";";
                endcase
            end
            KIND_GT:
            begin
                case (idx)
                    3'd0:    b = "&";
                    3'd1:    b = "g";
                    3'd2:    b = "t";
                    default: b = ";";
                endcase
            end
            KIND_QUOT:
            begin
                case (idx)
                    3'd0:    b = "&";
                    3'd1:    b = "q";
                    3'd2:    b = "u";
                    3'd3:    b = "o";
                    3'd4:    b = "t";
                    default: b = ";";
                endcase
            end
            KIND_APOS:
            begin
                case (idx)
                    3'd0:    b = "&";
                    3'd1:    b = "#";
                    3'd2:    b = "3";
                    3'd3:    b = "9";
                    default: b = ";";
                endcase
            end
            KIND_BRK:
            begin
                case (idx)
                    3'd0:    b = "<";
                    3'd1:    b = "b";
                    3'd2:    b = "r";
                    3'd3:    b = ">";
                    default: b = CHAR_LF;
                endcase
            end
            default: b = ch;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/esc_front.sv -----
// esc_front: accepts input bytes, classifies them into descriptors, tracks CR state.
// Depends on esc_pkg; feeds esc_queue.
`timescale 1ns / 1ps

module esc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    char_byte,
    input  logic          end_of_string,
    input  logic          push,
    output logic          full,
    input  logic          multiline,
    input  logic          q_full,
    output logic          q_push,
    output esc_pkg::desc_t q_desc
);
    import esc_pkg::*;

    logic  after_cr_reg;
    logic  after_cr_next;
    logic  accept;
    logic  emit;
    logic  next_cr;
    kind_t kind;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        emit    = 1'b1;
        next_cr = 1'b0;
        kind    = KIND_PASS;
        if (char_byte == CHAR_NUL) begin
            emit = 1'b0;
        end else if (multiline && (char_byte == CHAR_CR || char_byte == CHAR_LF)) begin
            if (char_byte == CHAR_LF && after_cr_reg) begin
                emit = 1'b0;
            end else begin
                kind    = KIND_BRK;
                next_cr = (char_byte == CHAR_CR);
            end
        end else begin
            case (char_byte)
                CHAR_AMP:  kind = KIND_AMP;
                CHAR_LT:   kind = KIND_LT;
                CHAR_GT:   kind = KIND_GT;
                CHAR_QUOT: kind = KIND_QUOT;
                CHAR_APOS: kind = KIND_APOS;
                default:   kind = KIND_PASS;
            endcase
        end
        after_cr_next = after_cr_reg;
        if (accept) begin
            after_cr_next = end_of_string ? 1'b0 : next_cr;
        end
    end

    assign q_push      = accept && emit;
    assign q_desc.kind = kind;
    assign q_desc.ch   = char_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            after_cr_reg <= 1'b0;
        end else begin
            after_cr_reg <= after_cr_next;
        end
    end

endmodule

// ----- rtl/esc_queue.sv -----
// esc_queue: small register queue of descriptors between front and back.
// Depends on esc_pkg for the descriptor type.
`timescale 1ns / 1ps

module esc_queue #(
    parameter int DEPTH = esc_pkg::ESC_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  esc_pkg::desc_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output esc_pkg::desc_t rd_data,
    output logic           empty
);
    import esc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/esc_back.sv -----
// esc_back: expands queued descriptors into output bytes, one per cycle while pop
// is high, into an output register. Depends on esc_pkg for the entity tables.
`timescale 1ns / 1ps

module esc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  esc_pkg::desc_t q_head,
    input  logic           q_empty,
    output logic           q_pop,
    output logic [7:0]     out_byte,
    output logic           last_of_run,
    output logic           empty,
    input  logic           pop
);
    import esc_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             load;
    logic             is_last;

    assign load    = !q_empty && (!valid_reg || pop);
    assign is_last = (idx_reg == kind_len(q_head.kind) - 1'b1);
    assign q_pop   = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            byte_next  = kind_byte(q_head.kind, idx_reg, q_head.ch);
            last_next  = is_last;
            idx_next   = is_last ? '0 : idx_reg + 1'b1;
        end else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;
    assign empty       = !valid_reg;

endmodule

// ----- rtl/html_entity_escaper.sv -----
// html_entity_escaper: top level of the streaming HTML entity escaper.
// Depends on esc_pkg, esc_front, esc_queue and esc_back.
//
// Usage:
//   Input queue side: drive char_byte and end_of_string with push high; the
//   transaction completes at a clock edge where full is low. Zero bytes and a
//   LF swallowed after a CR in multiline mode give no output bytes.
//   Output queue side: while empty is low, out_byte and last_of_run hold the
//   oldest output byte; pop high at a clock edge takes it. last_of_run marks
//   the final byte produced by one input transaction.
//   Configuration: cfg_we high at a clock edge loads cfg_wdata into the
//   multiline bit. Write only while the block is idle.
// Timing:
//   The first output byte passes the descriptor queue, then the output register.
//   The back end emits one byte per cycle while pop is high, and an input byte
//   expands to at most 6 output bytes (6 for a double quote); the output register sets that rate.
//   The front end takes one input per cycle while the descriptor queue
//   (QUEUE_DEPTH entries) has space.
// Reset: rst_n low empties the queue and output register, and clears the CR memory and mode.
// When pop is held low, the output register holds, the queue fills and full
// rises; no byte is lost.
`timescale 1ns / 1ps

module html_entity_escaper #(
    parameter int QUEUE_DEPTH = esc_pkg::ESC_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_byte,
    input  logic       end_of_string,
    input  logic       push,
    output logic       full,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       empty,
    input  logic       pop,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);
    import esc_pkg::*;

    logic  multiline_reg, multiline_next;
    logic  q_push, q_full, q_pop, q_empty;
    desc_t q_desc, q_head;

    always_comb
    begin
        multiline_next = cfg_we ? cfg_wdata : multiline_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            multiline_reg <= 1'b0;
        end else begin
            multiline_reg <= multiline_next;
        end
    end

    esc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_byte     (char_byte),
        .end_of_string (end_of_string),
        .push          (push),
        .full          (full),
        .multiline     (multiline_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_desc        (q_desc)
    );

    esc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_desc),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    esc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .empty       (empty),
        .pop         (pop)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("descriptor queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("descriptor queue underflow");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_of_run) |=> !empty)
        else $error("output run broken before its last byte");

endmodule
